[hdl/fdee_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Flow-direction edge emitter package
// Shared types, widths and direction tables for the D8 raster-to-graph block.
// ----------------------------------------------------------------------------
package fdee_pkg;

    localparam int MAX_DIM     = 4096;
    localparam int DIM_W       = 13;
    localparam int COORD_W     = 12;
    localparam int ID_W        = 24;
    localparam int EDGE_NUM_W  = 32;
    localparam int NUM_DIRS    = 8;
    localparam int DIR_IDX_W   = 3;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;
    localparam int QCNT_W      = 3;

    // configuration register indexes
    localparam logic REG_NUM_ROWS = 1'b0;
    localparam logic REG_NUM_COLS = 1'b1;

    // record kinds
    localparam logic REC_VERTEX = 1'b0;
    localparam logic REC_EDGE   = 1'b1;

    // masks that carry no edges
    localparam logic [NUM_DIRS-1:0] MASK_NONE = 8'h00;
    localparam logic [NUM_DIRS-1:0] MASK_ALL  = 8'hFF;

    // row and column steps for E, SE, S, SW, W, NW, N, NE
    localparam logic signed [1:0] DIR_DROW [NUM_DIRS] = '{
        2'sd0, 2'sd1, 2'sd1, 2'sd1, 2'sd0, -2'sd1, -2'sd1, -2'sd1
    };
    localparam logic signed [1:0] DIR_DCOL [NUM_DIRS] = '{
        2'sd1, 2'sd1, 2'sd0, -2'sd1, -2'sd1, -2'sd1, 2'sd0, 2'sd1
    };

    typedef struct packed {
        logic [COORD_W-1:0]  pixel_row;
        logic [COORD_W-1:0]  pixel_col;
        logic [NUM_DIRS-1:0] direction_mask;
    } fdee_pixel_t;

    typedef struct packed {
        logic                  record_kind;
        logic [ID_W-1:0]       from_vertex;
        logic [ID_W-1:0]       to_vertex;
        logic [EDGE_NUM_W-1:0] edge_number;
        logic                  last;
    } fdee_rec_t;

    // one classified pixel waiting for the back end
    typedef struct packed {
        logic [ID_W-1:0]     self_id;
        logic [NUM_DIRS-1:0] edge_mask;
    } fdee_job_t;

    typedef enum logic {
        ST_HEAD,
        ST_EDGE
    } fdee_state_t;

endpackage
`default_nettype wire

[hdl/flow_direction_edge_emitter.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Flow-direction edge emitter
// Turns pixels of a D8 flow-direction raster into vertex and edge records.
// ----------------------------------------------------------------------------
// The result channel carries one record per cycle while m_ready is high and jobs
// are queued: a valid pixel gives one record for the vertex plus one for each
// emitted edge, so 1 to 8 records; a pixel outside the valid area is consumed
// and produces nothing. A four-entry job queue lets the input side keep taking
// pixels while the back end drains earlier ones. num_rows and num_cols are
// written through the cfg port, clamp to 4096, and must only change while the
// block is idle.
module flow_direction_edge_emitter (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        cfg_wr_en,
    input  wire logic                        cfg_wr_index,
    input  wire logic [fdee_pkg::DIM_W-1:0]  cfg_wr_data,
    input  wire logic                        s_valid,
    output logic                             s_ready,
    input  wire fdee_pkg::fdee_pixel_t       s_data,
    output logic                             m_valid,
    input  wire logic                        m_ready,
    output fdee_pkg::fdee_rec_t              m_data
);

    logic                          q_full;
    logic                          q_push;
    fdee_pkg::fdee_job_t           q_push_job;
    logic                          q_pop;
    logic                          q_head_valid;
    fdee_pkg::fdee_job_t           q_head_job;
    logic [fdee_pkg::DIM_W-1:0]    num_cols;

    fdee_front u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_index (cfg_wr_index),
        .cfg_wr_data  (cfg_wr_data),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_data       (s_data),
        .q_full       (q_full),
        .q_push       (q_push),
        .q_job        (q_push_job),
        .num_cols     (num_cols)
    );

    fdee_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_job   (q_push_job),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_head_valid),
        .head_job   (q_head_job)
    );

    fdee_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .num_cols (num_cols),
        .q_valid  (q_head_valid),
        .q_job    (q_head_job),
        .q_pop    (q_pop),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

endmodule
`default_nettype wire

[hdl/fdee_front.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Front end
// Holds the raster size registers, checks each pixel against the valid area,
// computes its vertex id and the set of edges whose neighbours are valid.
// ----------------------------------------------------------------------------
module fdee_front (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        cfg_wr_en,
    input  wire logic                        cfg_wr_index,
    input  wire logic [fdee_pkg::DIM_W-1:0]  cfg_wr_data,
    input  wire logic                        s_valid,
    output logic                             s_ready,
    input  wire fdee_pkg::fdee_pixel_t       s_data,
    input  wire logic                        q_full,
    output logic                             q_push,
    output fdee_pkg::fdee_job_t              q_job,
    output logic [fdee_pkg::DIM_W-1:0]       num_cols
);

    logic [fdee_pkg::DIM_W-1:0] num_rows_reg, num_rows_next;
    logic [fdee_pkg::DIM_W-1:0] num_cols_reg, num_cols_next;
    logic [fdee_pkg::DIM_W-1:0] cfg_sat;
    logic [fdee_pkg::DIM_W-1:0] row_x, col_x;
    logic                       pixel_ok;
    logic                       down_ok, up_ok, right_ok, left_ok;
    logic                       mask_live;
    logic                       row_ok, col_ok;
    logic [fdee_pkg::ID_W-1:0]  product;

    // clamp writes to the largest raster
    assign cfg_sat = (cfg_wr_data > fdee_pkg::DIM_W'(fdee_pkg::MAX_DIM))
                   ? fdee_pkg::DIM_W'(fdee_pkg::MAX_DIM) : cfg_wr_data;

    always_comb begin
        num_rows_next = num_rows_reg;
        num_cols_next = num_cols_reg;
        if (cfg_wr_en) begin
            unique case (cfg_wr_index)
                fdee_pkg::REG_NUM_ROWS: num_rows_next = cfg_sat;
                fdee_pkg::REG_NUM_COLS: num_cols_next = cfg_sat;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            num_rows_reg <= fdee_pkg::DIM_W'(fdee_pkg::MAX_DIM);
            num_cols_reg <= fdee_pkg::DIM_W'(fdee_pkg::MAX_DIM);
        end else begin
            num_rows_reg <= num_rows_next;
            num_cols_reg <= num_cols_next;
        end
    end

    assign num_cols = num_cols_reg;

    assign row_x = {1'b0, s_data.pixel_row};
    assign col_x = {1'b0, s_data.pixel_col};

    assign pixel_ok = (s_data.pixel_row != '0) && (row_x < num_rows_reg)
                   && (s_data.pixel_col != '0) && (col_x < num_cols_reg);

    assign down_ok  = (row_x + 13'd1) < num_rows_reg;
    assign up_ok    = s_data.pixel_row >= 12'd2;
    assign right_ok = (col_x + 13'd1) < num_cols_reg;
    assign left_ok  = s_data.pixel_col >= 12'd2;

    assign mask_live = (s_data.direction_mask != fdee_pkg::MASK_NONE)
                    && (s_data.direction_mask != fdee_pkg::MASK_ALL);

    assign product = {{(fdee_pkg::ID_W-fdee_pkg::COORD_W){1'b0}}, s_data.pixel_row}
                   * {{(fdee_pkg::ID_W-fdee_pkg::DIM_W){1'b0}}, num_cols_reg};

    always_comb begin
        q_job.self_id = product
                      + {{(fdee_pkg::ID_W-fdee_pkg::COORD_W){1'b0}}, s_data.pixel_col};
        q_job.edge_mask = '0;
        row_ok = 1'b0;
        col_ok = 1'b0;
        for (int d = 0; d < fdee_pkg::NUM_DIRS; d++) begin
            if (fdee_pkg::DIR_DROW[d] > 0)      row_ok = down_ok;
            else if (fdee_pkg::DIR_DROW[d] < 0) row_ok = up_ok;
            else                                row_ok = 1'b1;
            if (fdee_pkg::DIR_DCOL[d] > 0)      col_ok = right_ok;
            else if (fdee_pkg::DIR_DCOL[d] < 0) col_ok = left_ok;
            else                                col_ok = 1'b1;
            q_job.edge_mask[d] = mask_live && s_data.direction_mask[d] && row_ok && col_ok;
        end
    end

    // drop pixels outside the valid area; they still complete their transaction
    assign s_ready = !q_full;
    assign q_push  = s_valid && !q_full && pixel_ok;

endmodule
`default_nettype wire

[hdl/fdee_queue.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Job queue
// Small first-in first-out buffer between the front end and the back end.
// ----------------------------------------------------------------------------
module fdee_queue (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                push,
    input  wire fdee_pkg::fdee_job_t push_job,
    output logic                     full,
    input  wire logic                pop,
    output logic                     head_valid,
    output fdee_pkg::fdee_job_t      head_job
);

    fdee_pkg::fdee_job_t               entry_reg [fdee_pkg::QUEUE_DEPTH];
    logic [fdee_pkg::QPTR_W-1:0]       wr_ptr_reg, wr_ptr_next;
    logic [fdee_pkg::QPTR_W-1:0]       rd_ptr_reg, rd_ptr_next;
    logic [fdee_pkg::QCNT_W-1:0]       count_reg, count_next;
    logic                              do_push, do_pop;

    assign full       = count_reg == fdee_pkg::QCNT_W'(fdee_pkg::QUEUE_DEPTH);
    assign head_valid = count_reg != '0;
    assign head_job   = entry_reg[rd_ptr_reg];

    assign do_push = push && !full;
    assign do_pop  = pop && head_valid;

    always_comb begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)      count_next = count_reg + 1'b1;
        else if (do_pop && !do_push) count_next = count_reg - 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule
`default_nettype wire

[hdl/fdee_back.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Back end
// Emits the vertex record straight from the queue head, then walks the
// pending edge bits lowest first, numbering each edge; one record per cycle when not stalled.
// ----------------------------------------------------------------------------
module fdee_back (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic [fdee_pkg::DIM_W-1:0]  num_cols,
    input  wire logic                        q_valid,
    input  wire fdee_pkg::fdee_job_t         q_job,
    output logic                             q_pop,
    output logic                             m_valid,
    input  wire logic                        m_ready,
    output fdee_pkg::fdee_rec_t              m_data
);

    fdee_pkg::fdee_state_t                state_reg, state_next;
    logic [fdee_pkg::ID_W-1:0]            self_reg, self_next;
    logic [fdee_pkg::NUM_DIRS-1:0]        pend_reg, pend_next;
    logic [fdee_pkg::EDGE_NUM_W-1:0]      edge_counter_reg, edge_counter_next;
    logic                                 m_valid_reg, m_valid_next;
    fdee_pkg::fdee_rec_t                  m_data_reg, m_data_next;

    logic                                 out_free;
    logic                                 rec_load;
    logic [fdee_pkg::DIR_IDX_W-1:0]       sel_dir;
    logic [fdee_pkg::NUM_DIRS-1:0]        pend_left;
    logic [fdee_pkg::ID_W-1:0]            cols_x;
    logic [fdee_pkg::ID_W-1:0]            row_base;
    logic [fdee_pkg::ID_W-1:0]            nbr_id;

    assign out_free = !m_valid_reg || m_ready;

    // lowest pending direction
    always_comb begin
        sel_dir = '0;
        for (int i = fdee_pkg::NUM_DIRS - 1; i >= 0; i--) begin
            if (pend_reg[i]) sel_dir = fdee_pkg::DIR_IDX_W'(i);
        end
    end

    assign pend_left = pend_reg & (pend_reg - 8'd1);
    assign cols_x    = {{(fdee_pkg::ID_W-fdee_pkg::DIM_W){1'b0}}, num_cols};

    always_comb begin
        if (fdee_pkg::DIR_DROW[sel_dir] > 0)      row_base = self_reg + cols_x;
        else if (fdee_pkg::DIR_DROW[sel_dir] < 0) row_base = self_reg - cols_x;
        else                                      row_base = self_reg;
        if (fdee_pkg::DIR_DCOL[sel_dir] > 0)      nbr_id = row_base + 24'd1;
        else if (fdee_pkg::DIR_DCOL[sel_dir] < 0) nbr_id = row_base - 24'd1;
        else                                      nbr_id = row_base;
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            fdee_pkg::ST_HEAD: begin
                if (out_free && q_valid && (q_job.edge_mask != '0)) begin
                    state_next = fdee_pkg::ST_EDGE;
                end
            end
            fdee_pkg::ST_EDGE: begin
                if (out_free && (pend_left == '0)) begin
                    state_next = fdee_pkg::ST_HEAD;
                end
            end
            default: state_next = fdee_pkg::ST_HEAD;
        endcase
    end

    // outputs and datapath
    always_comb begin
        q_pop             = 1'b0;
        rec_load          = 1'b0;
        self_next         = self_reg;
        pend_next         = pend_reg;
        edge_counter_next = edge_counter_reg;
        m_data_next       = m_data_reg;
        unique case (state_reg)
            fdee_pkg::ST_HEAD: begin
                if (out_free && q_valid) begin
                    q_pop                   = 1'b1;
                    rec_load                = 1'b1;
                    self_next               = q_job.self_id;
                    pend_next               = q_job.edge_mask;
                    m_data_next.record_kind = fdee_pkg::REC_VERTEX;
                    m_data_next.from_vertex = q_job.self_id;
                    m_data_next.to_vertex   = '0;
                    m_data_next.edge_number = '0;
                    m_data_next.last        = q_job.edge_mask == '0;
                end
            end
            fdee_pkg::ST_EDGE: begin
                if (out_free) begin
                    rec_load                = 1'b1;
                    pend_next               = pend_left;
                    edge_counter_next       = edge_counter_reg + 32'd1;
                    m_data_next.record_kind = fdee_pkg::REC_EDGE;
                    m_data_next.from_vertex = self_reg;
                    m_data_next.to_vertex   = nbr_id;
                    m_data_next.edge_number = edge_counter_reg;
                    m_data_next.last        = pend_left == '0;
                end
            end
            default: ;
        endcase
        m_valid_next = rec_load ? 1'b1 : (m_ready ? 1'b0 : m_valid_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= fdee_pkg::ST_HEAD;
            pend_reg         <= '0;
            edge_counter_reg <= '0;
            m_valid_reg      <= 1'b0;
        end else begin
            state_reg        <= state_next;
            pend_reg         <= pend_next;
            edge_counter_reg <= edge_counter_next;
            m_valid_reg      <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        self_reg   <= self_next;
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

`ifndef SYNTHESIS
    a_edge_state_has_work: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == fdee_pkg::ST_EDGE |-> pend_reg != '0)
        else $error("edge state with no pending edges");

    a_edge_counts_once: assert property (@(posedge aclk) disable iff (!aresetn)
        rec_load && m_data_next.record_kind == fdee_pkg::REC_EDGE
        |=> edge_counter_reg == $past(edge_counter_reg) + 32'd1)
        else $error("edge counter did not advance by one per edge");

    a_vertex_pops_queue: assert property (@(posedge aclk) disable iff (!aresetn)
        rec_load && m_data_next.record_kind == fdee_pkg::REC_VERTEX |-> q_pop && q_valid)
        else $error("vertex record without a queue pop");

    a_last_ends_pixel: assert property (@(posedge aclk) disable iff (!aresetn)
        rec_load && m_data_next.last |=> state_reg == fdee_pkg::ST_HEAD)
        else $error("last record but edges still pending");
`endif

endmodule
`default_nettype wire
